@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the evaluator unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property that is not checked while reset is asserted.
`define CCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked property that is checked at every edge, reset included.
`define CCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/ccr_pkg.sv @@
`default_nettype none
package ccr_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int COORD_W    = 24;
  localparam int T_W        = 24;
  localparam int T_FRAC     = 16;
  localparam int TI_W       = T_W - T_FRAC;
  localparam int POS_W      = 25;
  localparam int TAN_W      = 26;
  localparam int PT_W       = 3 * COORD_W;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd6;
  localparam logic [CNT_W-1:0] CNT_MAX   = 5'd16;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] n0;
    logic [IDX_W-1:0] n1;
    logic [IDX_W-1:0] n2;
    logic [IDX_W-1:0] n3;
  } nbr_t;

  // 256 mod n for the point counts in use.
  function automatic logic [CNT_W-1:0] mod256(input logic [CNT_W-1:0] n);
    case (n)
      5'd3:    return 5'd1;
      5'd5:    return 5'd1;
      5'd6:    return 5'd4;
      5'd7:    return 5'd4;
      5'd9:    return 5'd4;
      5'd10:   return 5'd6;
      5'd11:   return 5'd3;
      5'd12:   return 5'd4;
      5'd13:   return 5'd9;
      5'd14:   return 5'd4;
      5'd15:   return 5'd1;
      default: return 5'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ccr_if.sv @@
`default_nettype none
interface ccr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic        [ccr_pkg::IDX_W-1:0]     point_index;
  logic signed [ccr_pkg::COORD_W-1:0]   point_x;
  logic signed [ccr_pkg::COORD_W-1:0]   point_y;
  logic signed [ccr_pkg::COORD_W-1:0]   point_z;
  logic signed [ccr_pkg::T_W-1:0]       param_t;

  modport source (output valid, func, point_index, point_x, point_y, point_z, param_t,
                  input ready);
  modport sink (input valid, func, point_index, point_x, point_y, point_z, param_t,
                output ready);
endinterface

interface ccr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ccr_pkg::POS_W-1:0]   pos_x;
  logic signed [ccr_pkg::POS_W-1:0]   pos_y;
  logic signed [ccr_pkg::POS_W-1:0]   pos_z;
  logic signed [ccr_pkg::TAN_W-1:0]   tangent_x;
  logic signed [ccr_pkg::TAN_W-1:0]   tangent_y;
  logic signed [ccr_pkg::TAN_W-1:0]   tangent_z;

  modport source (output valid, pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/ccr_index.sv @@
`default_nettype none
// Reduces the integer part of t modulo the point count over two register
// stages (four restoring steps each) and derives the four neighbor slots.
module ccr_index (
  input  wire                           clk,
  input  wire                           adv,
  input  wire [ccr_pkg::TI_W-1:0]       ti_i,
  input  wire [ccr_pkg::CNT_W-1:0]      cnt_i,
  output ccr_pkg::nbr_t                 nbr_o
);

  logic [ccr_pkg::TI_W-1:0]  rem_b_r, rem_b_nxt;
  logic                      neg_b_r;
  logic [ccr_pkg::TI_W-1:0]  rem_c_r, rem_c_nxt;
  logic                      neg_c_r;

  always_comb begin
    logic [12:0] trial;
    logic [12:0] sub;
    trial = {5'd0, ti_i};
    for (int k = 7; k >= 4; k--) begin
      sub = 13'(cnt_i) << k;
      if (trial >= sub) begin
        trial = trial - sub;
      end
    end
    rem_b_nxt = trial[7:0];
  end

  always_comb begin
    logic [12:0] trial;
    logic [12:0] sub;
    trial = {5'd0, rem_b_r};
    for (int k = 3; k >= 0; k--) begin
      sub = 13'(cnt_i) << k;
      if (trial >= sub) begin
        trial = trial - sub;
      end
    end
    rem_c_nxt = trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_b_r <= rem_b_nxt;
      neg_b_r <= ti_i[ccr_pkg::TI_W-1];
      rem_c_r <= rem_c_nxt;
      neg_c_r <= neg_b_r;
    end
  end

  // A negative integer part was reduced as its unsigned pattern, which is
  // 256 too large; take 256 mod count back out.
  logic [ccr_pkg::CNT_W-1:0] corr;
  logic [ccr_pkg::CNT_W-1:0] rem5;
  logic [ccr_pkg::CNT_W-1:0] idx;
  logic [ccr_pkg::CNT_W-1:0] nx0, nx2, nx3;

  always_comb begin
    corr = ccr_pkg::mod256(cnt_i);
    rem5 = rem_c_r[ccr_pkg::CNT_W-1:0];
    if (!neg_c_r) begin
      idx = rem5;
    end else if (rem5 >= corr) begin
      idx = rem5 - corr;
    end else begin
      idx = rem5 + cnt_i - corr;
    end
    nx0 = (idx == 5'd0) ? cnt_i - 5'd1 : idx - 5'd1;
    nx2 = (idx + 5'd1 == cnt_i) ? 5'd0 : idx + 5'd1;
    nx3 = (nx2 + 5'd1 == cnt_i) ? 5'd0 : nx2 + 5'd1;
    nbr_o.n0 = nx0[ccr_pkg::IDX_W-1:0];
    nbr_o.n1 = idx[ccr_pkg::IDX_W-1:0];
    nbr_o.n2 = nx2[ccr_pkg::IDX_W-1:0];
    nbr_o.n3 = nx3[ccr_pkg::IDX_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/ccr_point_mem.sv @@
`default_nettype none
// Point table held as four identical copies, one read port each.
module ccr_point_mem (
  input  wire                                      clk,
  input  wire                                      adv,
  input  wire                                      we_i,
  input  wire [ccr_pkg::IDX_W-1:0]                 waddr_i,
  input  wire [ccr_pkg::PT_W-1:0]                  wdata_i,
  input  wire [3:0][ccr_pkg::IDX_W-1:0]            raddr_i,
  output logic [3:0][ccr_pkg::PT_W-1:0]            rdata_o
);

  for (genvar g = 0; g < 4; g++) begin : g_copy
    logic [ccr_pkg::PT_W-1:0] mem [ccr_pkg::MAX_POINTS];
    logic [ccr_pkg::PT_W-1:0] q_r;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (we_i) begin
          mem[waddr_i] <= wdata_i;
        end
        q_r <= mem[raddr_i[g]];
      end
    end

    assign rdata_o[g] = q_r;
  end

endmodule
`default_nettype wire

@@ rtl/core/ccr_arith.sv @@
`default_nettype none
// One coordinate of the curve: differences, Horner steps for position and
// tangent, rounding and saturation over seven register stages.
module ccr_arith (
  input  wire                                   clk,
  input  wire                                   adv,
  input  wire signed [ccr_pkg::COORD_W-1:0]     p0_i,
  input  wire signed [ccr_pkg::COORD_W-1:0]     p1_i,
  input  wire signed [ccr_pkg::COORD_W-1:0]     p2_i,
  input  wire signed [ccr_pkg::COORD_W-1:0]     p3_i,
  input  wire [ccr_pkg::T_FRAC-1:0]             u_i,
  output logic signed [ccr_pkg::POS_W-1:0]      pos_o,
  output logic signed [ccr_pkg::TAN_W-1:0]      tan_o
);

  // Stage E
  logic signed [24:0] d1_e_r, d1_nxt;
  logic signed [27:0] d2_e_r, d2_nxt;
  logic signed [26:0] d3_e_r, d3_nxt;
  logic signed [23:0] p1_e_r;
  logic [15:0]        u_e_r;
  // Stage F
  logic signed [43:0] m3_f_r, m3_nxt;
  logic signed [24:0] d1_f_r;
  logic signed [27:0] d2_f_r;
  logic signed [23:0] p1_f_r;
  logic [15:0]        u_f_r;
  // Stage G
  logic signed [28:0] h2_g_r, h2_nxt;
  logic signed [29:0] g2_g_r, g2_nxt;
  logic signed [24:0] d1_g_r;
  logic signed [23:0] p1_g_r;
  logic [15:0]        u_g_r;
  // Stage H
  logic signed [45:0] mh_h_r, mh_nxt;
  logic signed [46:0] mg_h_r, mg_nxt;
  logic signed [24:0] d1_h_r;
  logic signed [23:0] p1_h_r;
  logic [15:0]        u_h_r;
  // Stage I
  logic signed [29:0] h1_i_r, h1_nxt;
  logic signed [25:0] tan_i_r, tan_nxt;
  logic signed [23:0] p1_i_r;
  logic [15:0]        u_i_r;
  // Stage J
  logic signed [46:0] mp_j_r, mp_nxt;
  logic signed [25:0] tan_j_r;
  logic signed [23:0] p1_j_r;
  // Stage K
  logic signed [24:0] pos_nxt;

  logic signed [16:0] us_e, us_g, us_i;
  logic signed [44:0] h2_sum;
  logic signed [46:0] g2_sum;
  logic signed [46:0] h1_sum;
  logic signed [47:0] tn_sum;
  logic signed [47:0] ps_sum;
  logic signed [30:0] tn_full;
  logic signed [30:0] ps_full;

  assign us_e = $signed({1'b0, u_e_r});
  assign us_g = $signed({1'b0, u_g_r});
  assign us_i = $signed({1'b0, u_i_r});

  assign d1_nxt = 25'(p2_i) - 25'(p0_i);
  assign d2_nxt = (28'(p0_i) <<< 1) - (28'(p1_i) <<< 2) - 28'(p1_i)
                + (28'(p2_i) <<< 2) - 28'(p3_i);
  assign d3_nxt = 27'(p3_i) - 27'(p0_i) + (27'(p1_i) <<< 1) + 27'(p1_i)
                - (27'(p2_i) <<< 1) - 27'(p2_i);

  assign m3_nxt = d3_e_r * us_e;

  assign h2_sum = (45'(d2_f_r) <<< 16) + 45'(m3_f_r) + 45'sd32768;
  assign h2_nxt = h2_sum[44:16];
  assign g2_sum = (47'(d2_f_r) <<< 17) + 47'(m3_f_r) + (47'(m3_f_r) <<< 1) + 47'sd32768;
  assign g2_nxt = g2_sum[45:16];

  assign mh_nxt = h2_g_r * us_g;
  assign mg_nxt = g2_g_r * us_g;

  assign h1_sum  = (47'(d1_h_r) <<< 16) + 47'(mh_h_r) + 47'sd32768;
  assign h1_nxt  = h1_sum[45:16];
  assign tn_sum  = (48'(d1_h_r) <<< 16) + 48'(mg_h_r) + 48'sd65536;
  assign tn_full = tn_sum[47:17];

  always_comb begin
    if (tn_full > 31'sd33554431) begin
      tan_nxt = 26'sd33554431;
    end else if (tn_full < -31'sd33554432) begin
      tan_nxt = -26'sd33554432;
    end else begin
      tan_nxt = tn_full[25:0];
    end
  end

  assign mp_nxt = h1_i_r * us_i;

  assign ps_sum  = (48'(p1_j_r) <<< 17) + 48'(mp_j_r) + 48'sd65536;
  assign ps_full = ps_sum[47:17];

  always_comb begin
    if (ps_full > 31'sd16777215) begin
      pos_nxt = 25'sd16777215;
    end else if (ps_full < -31'sd16777216) begin
      pos_nxt = -25'sd16777216;
    end else begin
      pos_nxt = ps_full[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_e_r  <= d1_nxt;
      d2_e_r  <= d2_nxt;
      d3_e_r  <= d3_nxt;
      p1_e_r  <= p1_i;
      u_e_r   <= u_i;

      m3_f_r  <= m3_nxt;
      d1_f_r  <= d1_e_r;
      d2_f_r  <= d2_e_r;
      p1_f_r  <= p1_e_r;
      u_f_r   <= u_e_r;

      h2_g_r  <= h2_nxt;
      g2_g_r  <= g2_nxt;
      d1_g_r  <= d1_f_r;
      p1_g_r  <= p1_f_r;
      u_g_r   <= u_f_r;

      mh_h_r  <= mh_nxt;
      mg_h_r  <= mg_nxt;
      d1_h_r  <= d1_g_r;
      p1_h_r  <= p1_g_r;
      u_h_r   <= u_g_r;

      h1_i_r  <= h1_nxt;
      tan_i_r <= tan_nxt;
      p1_i_r  <= p1_h_r;
      u_i_r   <= u_h_r;

      mp_j_r  <= mp_nxt;
      tan_j_r <= tan_i_r;
      p1_j_r  <= p1_i_r;

      pos_o   <= pos_nxt;
      tan_o   <= tan_j_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/closed_catmull_rom_evaluator_unit.sv @@
// An evaluate result passes the input registers (A, B, C), the table read
// and the arithmetic stages E to K; point writes reach the table from stage C.
// Throughput: one transaction per cycle; the whole pipeline advances as one
// and holds while a finished result waits on the output.
// Reset (synchronous, rst_n low) clears all valid bits and sets the point
// count to 6; the point table is not cleared and must be written first.
`default_nettype none
`include "assert_macros.svh"
module closed_catmull_rom_evaluator_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  ccr_in_if.sink                        in_ch,
  ccr_out_if.source                     out_ch,
  input  wire                           cfg_wr_en,
  input  wire [ccr_pkg::CNT_W-1:0]      cfg_wr_data
);

  logic                            adv;
  logic [ccr_pkg::CNT_W-1:0]       cnt_r;
  logic [ccr_pkg::CNT_W-1:0]       cnt_c;

  logic                            a_vld_r, b_vld_r, c_vld_r;
  logic                            a_func_r, b_func_r, c_func_r;
  logic [ccr_pkg::IDX_W-1:0]       a_slot_r, b_slot_r, c_slot_r;
  logic [ccr_pkg::PT_W-1:0]        a_pt_r, b_pt_r, c_pt_r;
  logic [ccr_pkg::TI_W-1:0]        a_ti_r;
  logic [ccr_pkg::T_FRAC-1:0]      a_u_r, b_u_r, c_u_r, d_u_r;
  logic [7:0]                      evl_r;

  ccr_pkg::nbr_t                                nbr;
  logic [3:0][ccr_pkg::IDX_W-1:0]               raddr;
  logic [3:0][ccr_pkg::PT_W-1:0]                rdata;
  logic                                         mem_we;

  assign adv         = !evl_r[7] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = evl_r[7];

  always_comb begin
    if (cnt_r == '0) begin
      cnt_c = 5'd1;
    end else if (cnt_r > ccr_pkg::CNT_MAX) begin
      cnt_c = ccr_pkg::CNT_MAX;
    end else begin
      cnt_c = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ccr_pkg::CNT_RESET;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      evl_r   <= '0;
    end else if (adv) begin
      a_vld_r <= in_ch.valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      evl_r   <= {evl_r[6:0], c_vld_r && (c_func_r == ccr_pkg::FUNC_EVAL)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_func_r <= in_ch.func;
      a_slot_r <= in_ch.point_index;
      a_pt_r   <= {in_ch.point_z, in_ch.point_y, in_ch.point_x};
      a_ti_r   <= in_ch.param_t[ccr_pkg::T_W-1:ccr_pkg::T_FRAC];
      a_u_r    <= in_ch.param_t[ccr_pkg::T_FRAC-1:0];
      b_func_r <= a_func_r;
      b_slot_r <= a_slot_r;
      b_pt_r   <= a_pt_r;
      b_u_r    <= a_u_r;
      c_func_r <= b_func_r;
      c_slot_r <= b_slot_r;
      c_pt_r   <= b_pt_r;
      c_u_r    <= b_u_r;
      d_u_r    <= c_u_r;
    end
  end

  ccr_index u_index (
    .clk   (clk),
    .adv   (adv),
    .ti_i  (a_ti_r),
    .cnt_i (cnt_c),
    .nbr_o (nbr)
  );

  assign raddr  = {nbr.n3, nbr.n2, nbr.n1, nbr.n0};
  // Writes reach the table at the same stage that evaluations read it, so
  // every transaction sees the table as its predecessors left it.
  assign mem_we = c_vld_r && (c_func_r == ccr_pkg::FUNC_WRITE);

  ccr_point_mem u_mem (
    .clk     (clk),
    .adv     (adv),
    .we_i    (mem_we),
    .waddr_i (c_slot_r),
    .wdata_i (c_pt_r),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic signed [2:0][ccr_pkg::POS_W-1:0] pos;
  logic signed [2:0][ccr_pkg::TAN_W-1:0] tan;

  for (genvar j = 0; j < 3; j++) begin : g_axis
    ccr_arith u_arith (
      .clk   (clk),
      .adv   (adv),
      .p0_i  (rdata[0][j*ccr_pkg::COORD_W +: ccr_pkg::COORD_W]),
      .p1_i  (rdata[1][j*ccr_pkg::COORD_W +: ccr_pkg::COORD_W]),
      .p2_i  (rdata[2][j*ccr_pkg::COORD_W +: ccr_pkg::COORD_W]),
      .p3_i  (rdata[3][j*ccr_pkg::COORD_W +: ccr_pkg::COORD_W]),
      .u_i   (d_u_r),
      .pos_o (pos[j]),
      .tan_o (tan[j])
    );
  end

  assign out_ch.pos_x     = pos[0];
  assign out_ch.pos_y     = pos[1];
  assign out_ch.pos_z     = pos[2];
  assign out_ch.tangent_x = tan[0];
  assign out_ch.tangent_y = tan[1];
  assign out_ch.tangent_z = tan[2];

  `CCR_ASSERT(a_write_no_result, clk, rst_n, (adv && c_vld_r && (c_func_r == ccr_pkg::FUNC_WRITE)) |=> !evl_r[0], "point write entered the result pipeline")
  `CCR_ASSERT(a_stall_holds, clk, rst_n, !adv |=> $stable(evl_r), "pipeline moved while stalled")
  `CCR_ASSERT(a_cnt_range, clk, rst_n, (cnt_c != 5'd0) && (cnt_c <= ccr_pkg::CNT_MAX), "clamped point count out of range")

endmodule
`default_nettype wire
